/* design/mqlb_pkg.sv */
package mqlb_pkg;

   // Fixed field widths of the command and response transactions
   localparam int ACT_W   = 1;
   localparam int QIDX_W  = 4;
   localparam int DATA_W  = 8;
   localparam int STAT_W  = 2;
   localparam int TDATA_W = 16;

   // Defaults for the top-level parameters
   localparam int NUM_QUEUES_DEF = 16;
   localparam int CAPACITY_DEF   = 256;

   // Command kinds
   localparam logic [ACT_W-1:0] ACT_ADD    = 1'b0;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 1'b1;

   // Response status codes
   typedef enum logic [STAT_W-1:0] {
      ST_ADDED   = 2'd0,
      ST_REMOVED = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;    // latch the command, read head and tail of its queue
      logic slot_read;  // read the byte and link store
      logic commit;     // apply the updates, load the response register
   } cmd_type;

endpackage

/* design/mqlb_ctrl.sv */
module mqlb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output mqlb_pkg::cmd_type cmd
);
   import mqlb_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      READ,
      COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The response register may be reloaded once its current content leaves
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      cmd.capture   = 1'b0;
      cmd.slot_read = 1'b0;
      cmd.commit    = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = READ;
            end
         end
         READ: begin
            cmd.slot_read = 1'b1;
            state_in      = COMMIT;
         end
         COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* design/mqlb_dp.sv */
module mqlb_dp #(
   parameter int NUM_QUEUES = mqlb_pkg::NUM_QUEUES_DEF,
   parameter int CAPACITY   = mqlb_pkg::CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mqlb_pkg::cmd_type             cmd,
   input  logic [mqlb_pkg::ACT_W-1:0]    req_action,
   input  logic [mqlb_pkg::QIDX_W-1:0]   req_queue,
   input  logic [mqlb_pkg::DATA_W-1:0]   req_data,
   output mqlb_pkg::status_type          rsp_status,
   output logic [mqlb_pkg::QIDX_W-1:0]   rsp_queue,
   output logic [mqlb_pkg::DATA_W-1:0]   rsp_data
);
   import mqlb_pkg::*;

   localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = SLOT_W + 1;
   localparam int QSEL_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int QCMP_W = (QSEL_W + 1 > QIDX_W) ? QSEL_W + 1 : QIDX_W + 1;

   // Shared slot store and per-queue pointers
   logic [DATA_W-1:0] slot_byte_mem [CAPACITY];
   logic [SLOT_W-1:0] slot_link_mem [CAPACITY];
   logic [SLOT_W-1:0] head_mem      [NUM_QUEUES];
   logic [SLOT_W-1:0] tail_mem      [NUM_QUEUES];

   logic [NUM_QUEUES-1:0] nonempty_ff, nonempty_in;
   logic [CNT_W-1:0]      fresh_used_ff, fresh_used_in;
   logic [SLOT_W-1:0]     free_head_ff, free_head_in;
   logic [CNT_W-1:0]      free_cnt_ff, free_cnt_in;

   logic [ACT_W-1:0]  action_ff;
   logic [QIDX_W-1:0] queue_ff;
   logic [DATA_W-1:0] data_ff;
   logic [SLOT_W-1:0] head_rd_ff, tail_rd_ff;
   logic [DATA_W-1:0] byte_rd_ff;
   logic [SLOT_W-1:0] link_rd_ff;

   status_type        status_ff, status_in;
   logic [QIDX_W-1:0] rsp_queue_ff;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [QSEL_W-1:0] req_sel, q_sel;
   logic              q_valid, q_busy, is_add;
   logic              fresh_avail, free_avail, add_ok, rem_ok, last_slot;
   logic [SLOT_W-1:0] new_slot, slot_addr;

   assign req_sel     = QSEL_W'(req_queue);
   assign q_sel       = QSEL_W'(queue_ff);
   assign q_valid     = QCMP_W'(queue_ff) < QCMP_W'(NUM_QUEUES);
   assign q_busy      = q_valid && nonempty_ff[q_sel];
   assign is_add      = (action_ff == ACT_ADD);
   assign fresh_avail = fresh_used_ff < CNT_W'(CAPACITY);
   assign free_avail  = (free_cnt_ff != '0);
   assign add_ok      = is_add && q_valid && (fresh_avail || free_avail);
   assign rem_ok      = !is_add && q_busy;
   assign new_slot    = fresh_avail ? fresh_used_ff[SLOT_W-1:0] : free_head_ff;
   assign last_slot   = (head_rd_ff == tail_rd_ff);
   assign slot_addr   = is_add ? free_head_ff : head_rd_ff;

   always_comb begin
      fresh_used_in = fresh_used_ff;
      free_head_in  = free_head_ff;
      free_cnt_in   = free_cnt_ff;
      nonempty_in   = nonempty_ff;
      rsp_data_in   = '0;
      status_in     = ST_EMPTY;
      if (is_add) begin
         status_in = add_ok ? ST_ADDED : ST_FULL;
         if (add_ok) begin
            if (fresh_avail) begin
               fresh_used_in = fresh_used_ff + CNT_W'(1);
            end else begin
               free_head_in = link_rd_ff;
               free_cnt_in  = free_cnt_ff - CNT_W'(1);
            end
            nonempty_in[q_sel] = 1'b1;
         end
      end else if (rem_ok) begin
         status_in    = ST_REMOVED;
         rsp_data_in  = byte_rd_ff;
         free_head_in = head_rd_ff;
         free_cnt_in  = free_cnt_ff + CNT_W'(1);
         if (last_slot) begin
            nonempty_in[q_sel] = 1'b0;
         end
      end
   end

   // Command latch and queue pointer read
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff  <= req_action;
         queue_ff   <= req_queue;
         data_ff    <= req_data;
         head_rd_ff <= head_mem[req_sel];
         tail_rd_ff <= tail_mem[req_sel];
      end
   end

   // Slot store read at the head (remove) or the free list head (add)
   always_ff @(posedge clock) begin
      if (cmd.slot_read) begin
         byte_rd_ff <= slot_byte_mem[slot_addr];
         link_rd_ff <= slot_link_mem[slot_addr];
      end
   end

   // Memory updates
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (add_ok) begin
            slot_byte_mem[new_slot] <= data_ff;
            tail_mem[q_sel]         <= new_slot;
            if (q_busy) begin
               slot_link_mem[tail_rd_ff] <= new_slot;
            end else begin
               head_mem[q_sel] <= new_slot;
            end
         end
         if (rem_ok) begin
            slot_link_mem[head_rd_ff] <= free_head_ff;
            if (!last_slot) begin
               head_mem[q_sel] <= link_rd_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff   <= '0;
         fresh_used_ff <= '0;
         free_head_ff  <= '0;
         free_cnt_ff   <= '0;
      end else if (cmd.commit) begin
         nonempty_ff   <= nonempty_in;
         fresh_used_ff <= fresh_used_in;
         free_head_ff  <= free_head_in;
         free_cnt_ff   <= free_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff    <= status_in;
         rsp_queue_ff <= queue_ff;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_queue  = rsp_queue_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

/* design/multi_queue_linked_buffer.sv */
// Channel  Direction  Handshake               tuser           tdata (low bit up)
// req      in         req_tvalid/req_tready   action          queue_index, data_in
// rsp      out        rsp_tvalid/rsp_tready   status          queue_echo, data_out
//
// One command is handled in order: read the queue's head and tail pointers, read the
// slot store at the head or the free list head, then commit the updates.
// The single-port slot store read followed by its write sets that order.
// Reset clears the queue valid bits and the slot counters; no store is swept.
// A response waiting on rsp_tready holds only the commit of the next command.
module multi_queue_linked_buffer #(
   parameter int NUM_QUEUES = mqlb_pkg::NUM_QUEUES_DEF,
   parameter int CAPACITY   = mqlb_pkg::CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mqlb_pkg::ACT_W-1:0]    req_tuser,  // action
   input  logic [mqlb_pkg::TDATA_W-1:0]  req_tdata,  // queue_index[3:0], data_in[11:4]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mqlb_pkg::STAT_W-1:0]   rsp_tuser,  // status
   output logic [mqlb_pkg::TDATA_W-1:0]  rsp_tdata   // queue_echo[3:0], data_out[11:4]
);
   import mqlb_pkg::*;

   localparam int PAD_W = TDATA_W - QIDX_W - DATA_W;

   cmd_type           cmd;
   status_type        rsp_status;
   logic [QIDX_W-1:0] rsp_queue;
   logic [DATA_W-1:0] rsp_data;

   // Sequence each command through read, slot read and commit
   mqlb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Slot store, queue pointers, free list and response register
   mqlb_dp #(
      .NUM_QUEUES (NUM_QUEUES),
      .CAPACITY   (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_action (req_tuser),
      .req_queue  (req_tdata[QIDX_W-1:0]),
      .req_data   (req_tdata[QIDX_W+DATA_W-1:QIDX_W]),
      .rsp_status (rsp_status),
      .rsp_queue  (rsp_queue),
      .rsp_data   (rsp_data)
   );

   // Pack the response transaction
   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {PAD_W'(0), rsp_data, rsp_queue};

   // An accepted command is answered before the next one is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready ##1 !req_tready)
      else $error("command accepted while previous one in flight");

   // Only a removal carries a byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_REMOVED)) |-> (rsp_tdata[QIDX_W+DATA_W-1:QIDX_W] == '0))
      else $error("nonzero data on a response that is not a removal");

   // A new response appears only right after the controller commits
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.commit))
      else $error("response raised without a commit");

endmodule

/* tb/tb_multi_queue_linked_buffer.sv */
`timescale 1ns / 1ps

module tb_multi_queue_linked_buffer;
   import mqlb_pkg::*;

   localparam int QUEUES    = NUM_QUEUES_DEF;
   localparam int SLOTS     = CAPACITY_DEF;
   localparam int RAND_CMDS = 530;

   // One command transaction as the driver sees it
   typedef struct {
      logic [ACT_W-1:0]  action;
      logic [QIDX_W-1:0] queue;
      logic [DATA_W-1:0] data;
      bit                hold_until_drained;  // send only once every response is back
   } command_type;

   // One response as the predictor expects it
   typedef struct {
      status_type        status;
      logic [QIDX_W-1:0] queue;
      logic [DATA_W-1:0] data;
   } response_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ACT_W-1:0]    req_tuser  = ACT_ADD;
   logic [TDATA_W-1:0]  req_tdata  = '0;       // queue_index[3:0], data_in[11:4]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [STAT_W-1:0]   rsp_tuser;             // status
   logic [TDATA_W-1:0]  rsp_tdata;             // queue_echo[3:0], data_out[11:4]

   command_type  pending_cmds[$];
   response_type expected_rsps[$];
   command_type  cmd_on_bus;
   response_type rsp_head;
   int        total_cmds  = 0;
   int        sent_cmds   = 0;
   int        error_count = 0;

   // Shadow of the linked slot store, the queue pointers and the slot allocator
   logic [DATA_W-1:0] shadow_byte[SLOTS];
   logic [7:0]        shadow_link[SLOTS];
   logic [7:0]        shadow_head[QUEUES];
   logic [7:0]        shadow_tail[QUEUES];
   bit                shadow_busy[QUEUES];
   int                fresh_count = 0;
   logic [7:0]        spare_head  = '0;
   int                spare_count = 0;

   multi_queue_linked_buffer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Apply one accepted command to the shadow store and return its response.
   function automatic response_type apply_command(command_type c);
      response_type r;
      logic [7:0] s;
      bit got;
      r.status = ST_EMPTY;
      r.queue  = c.queue;
      r.data   = '0;
      got      = 1'b0;
      s        = '0;
      if (c.action == ACT_ADD) begin
         // take a never-used slot first, then recycle from the free list
         if (fresh_count < SLOTS) begin
            s = fresh_count[7:0];
            fresh_count++;
            got = 1'b1;
         end else if (spare_count > 0) begin
            s = spare_head;
            spare_head = shadow_link[s];
            spare_count--;
            got = 1'b1;
         end
         if (got) begin
            shadow_byte[s] = c.data;
            if (shadow_busy[c.queue]) begin
               shadow_link[shadow_tail[c.queue]] = s;
               shadow_tail[c.queue] = s;
            end else begin
               shadow_head[c.queue] = s;
               shadow_tail[c.queue] = s;
               shadow_busy[c.queue] = 1'b1;
            end
            r.status = ST_ADDED;
         end else begin
            r.status = ST_FULL;
         end
      end else if (shadow_busy[c.queue]) begin
         s = shadow_head[c.queue];
         r.data = shadow_byte[s];
         // advance the head before the slot's link is reused for the free list
         if (s == shadow_tail[c.queue])
            shadow_busy[c.queue] = 1'b0;
         else
            shadow_head[c.queue] = shadow_link[s];
         shadow_link[s] = spare_head;
         spare_head = s;
         spare_count++;
         r.status = ST_REMOVED;
      end
      return r;
   endfunction

   // Idle and stall rates: sender light and receiver heavy, then swapped, then none.
   function automatic int sender_idle_pct();
      if (sent_cmds < total_cmds / 3)
         return 14;
      else if (sent_cmds < 2 * total_cmds / 3)
         return 51;
      return 0;
   endfunction

   function automatic int receiver_stall_pct();
      if (sent_cmds < total_cmds / 3)
         return 51;
      else if (sent_cmds < 2 * total_cmds / 3)
         return 14;
      return 0;
   endfunction

   task automatic queue_command(logic [ACT_W-1:0] act, int q, int d, bit hold);
      command_type c;
      c.action = act;
      c.queue  = q[QIDX_W-1:0];
      c.data   = d[DATA_W-1:0];
      c.hold_until_drained = hold;
      pending_cmds.push_back(c);
   endtask

   // Driver: predict on acceptance, then load the next command or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(apply_command(cmd_on_bus));
            sent_cmds++;
         end
         if (!req_tvalid || req_tready) begin
            // hold a marked command until the block has answered everything
            if (pending_cmds.size() > 0 &&
                !(pending_cmds[0].hold_until_drained && expected_rsps.size() > 0) &&
                $urandom_range(99) >= sender_idle_pct()) begin
               cmd_on_bus = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= cmd_on_bus.action;
               req_tdata  <= {4'b0, cmd_on_bus.data, cmd_on_bus.queue};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each response transaction against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, status %0d queue %0d data %02h",
                        $time, rsp_tuser, rsp_tdata[3:0], rsp_tdata[11:4]);
               error_count++;
            end else begin
               rsp_head = expected_rsps.pop_front();
               if (rsp_tuser !== rsp_head.status) begin
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, rsp_head.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[3:0] !== rsp_head.queue) begin
                  $display("%0t: queue echo mismatch, expected %0d actual %0d",
                           $time, rsp_head.queue, rsp_tdata[3:0]);
                  error_count++;
               end
               if (rsp_tdata[11:4] !== rsp_head.data) begin
                  $display("%0t: data mismatch on queue %0d, expected %02h actual %02h",
                           $time, rsp_head.queue, rsp_head.data, rsp_tdata[11:4]);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct());
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int stored;
      int full_hits;
      int q;
      int depth[QUEUES];
      bit filling;
      bit is_add;

      // empty queues at both index extremes
      queue_command(ACT_REMOVE, 0, 8'h00, 1'b0);
      queue_command(ACT_REMOVE, 15, 8'hFF, 1'b0);
      // a zero byte is ordinary data; extremes of the byte field
      queue_command(ACT_ADD, 0, 8'h00, 1'b0);
      queue_command(ACT_ADD, 0, 8'hFF, 1'b0);
      queue_command(ACT_ADD, 15, 8'hA5, 1'b0);
      queue_command(ACT_ADD, 15, 8'h5A, 1'b0);
      queue_command(ACT_REMOVE, 0, 8'hFF, 1'b0);
      queue_command(ACT_REMOVE, 0, 8'h00, 1'b0);
      queue_command(ACT_REMOVE, 0, 8'h00, 1'b0);
      // append behind an older byte, then drain in order
      queue_command(ACT_REMOVE, 15, 8'h00, 1'b0);
      queue_command(ACT_ADD, 15, 8'h3C, 1'b0);
      queue_command(ACT_REMOVE, 15, 8'h00, 1'b0);
      queue_command(ACT_REMOVE, 15, 8'h00, 1'b0);
      queue_command(ACT_REMOVE, 15, 8'h00, 1'b0);
      // independent queues side by side
      queue_command(ACT_ADD, 7, 8'h80, 1'b0);
      queue_command(ACT_ADD, 8, 8'h01, 1'b0);
      queue_command(ACT_REMOVE, 8, 8'h00, 1'b0);
      queue_command(ACT_REMOVE, 7, 8'h00, 1'b0);

      // Random part: fill until the store overflows, drain, refill from the free list.
      // Track occupancy here only to steer the add/remove mix.
      stored    = 0;
      full_hits = 0;
      filling   = 1'b1;
      foreach (depth[i])
         depth[i] = 0;
      for (int i = 0; i < RAND_CMDS; i++) begin
         q = $urandom_range(QUEUES - 1);
         is_add = ($urandom_range(99) < (filling ? 90 : 15));
         queue_command(is_add ? ACT_ADD : ACT_REMOVE, q, $urandom_range(255), (i % 170) == 0);
         if (is_add) begin
            if (stored < SLOTS) begin
               stored++;
               depth[q]++;
            end else begin
               full_hits++;
            end
         end else if (depth[q] > 0) begin
            depth[q]--;
            stored--;
         end
         if (filling && full_hits >= 8) begin
            filling = 1'b0;
            full_hits = 0;
         end else if (!filling && stored <= 24) begin
            filling = 1'b1;
         end
      end
      total_cmds = pending_cmds.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // wait for every command to be taken and answered, then let the pipe settle;
      // sample between edges so the driver and monitor updates have landed
      while (pending_cmds.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

/* filelist.f */
design/mqlb_pkg.sv
design/mqlb_ctrl.sv
design/mqlb_dp.sv
design/multi_queue_linked_buffer.sv
tb/tb_multi_queue_linked_buffer.sv
